// File: rtl/tccw_pkg.sv
package tccw_pkg;

	// Screen geometry and tab expansion
	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int TAB_SPACES  = 4;
	localparam int MAX_RESULTS = 4;

	// Spaces written for one tab, held between one and the result limit
	localparam int TAB_RESULTS = (TAB_SPACES > MAX_RESULTS) ? MAX_RESULTS :
		((TAB_SPACES < 1) ? 1 : TAB_SPACES);
	localparam int TAB_CNT_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

	// Field widths
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int ADDR_W  = 11;
	localparam int VALUE_W = 16;

	// Command codes
	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_SET = 1'b1;

	// Character codes with special handling
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd7;

	// Input word
	typedef struct packed {
		logic              command;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_W-1:0]  new_row;
		logic [COL_W-1:0]  new_col;
	} cmd_word_t;

	// Result word
	typedef struct packed {
		logic               write_enable;
		logic [ADDR_W-1:0]  cell_address;
		logic [VALUE_W-1:0] cell_value;
		logic [ROW_W-1:0]   cursor_row;
		logic [COL_W-1:0]   cursor_col;
		logic               last;
	} res_word_t;

endpackage

// File: rtl/text_console_char_writer_unit.sv
// Text console character writer. Each command word either puts a character at the
// cursor of a COLUMNS x ROWS text screen or moves the cursor, and the block answers
// with result words carrying an optional cell write ({colour, character} at
// row * COLUMNS + column) and the cursor after that result; last marks the final
// result of a command. A command word can be taken every cycle and gives one result
// word per cycle while the result side does not stall; a tab gives TAB_RESULTS
// result words (four by default) and everything else one. The rate is set by the
// cursor register, which is read and updated once per result, with one input register
// and one result register around the update logic, which a command's result words pass
// through in that order. The colour register is written through cfg_data, always ready,
// and must only be written while no command is in flight.
module text_console_char_writer_unit
	import tccw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  cmd_word_t          cmd_word,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output res_word_t          res_word,
	// colour register write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COLOR_W-1:0] cfg_data
);

	// registers
	logic                 valid_s1;
	cmd_word_t            item_s1;
	logic [TAB_CNT_W-1:0] tab_cnt_s1;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic [COLOR_W-1:0]   color_q;
	logic                 res_valid_q;
	res_word_t            res_word_q;

	// decode and next-cursor logic
	logic             is_set, is_nl, is_tab, is_bs;
	logic             last_res, fire;
	logic [ROW_W-1:0] row_adv, row_nx, wr_row;
	logic [COL_W-1:0] col_adv, col_nx, wr_col;
	logic             col_wrap;
	logic             we;
	logic [CHAR_W-1:0] wr_char;
	res_word_t        res_nx;

	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	// command decode
	assign is_set = (item_s1.command == CMD_SET);
	assign is_nl  = !is_set && (item_s1.char_code == CH_NEWLINE);
	assign is_tab = !is_set && (item_s1.char_code == CH_TAB);
	assign is_bs  = !is_set && (item_s1.char_code == CH_BACKSPACE) && (col_q != '0);

	assign last_res = !is_tab || (tab_cnt_s1 == TAB_CNT_W'(TAB_RESULTS - 1));
	assign fire     = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !(fire && last_res);

	// plain advance of the cursor, wrapping column then row
	assign col_wrap = (col_q == COL_W'(COLUMNS - 1));
	assign col_adv  = col_wrap ? '0 : col_q + COL_W'(1);
	always_comb begin
		row_adv = row_q;
		if (col_wrap) begin
			row_adv = (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + ROW_W'(1);
		end
	end

	// next cursor, write position and character per command kind
	always_comb begin
		row_nx  = row_adv;
		col_nx  = col_adv;
		wr_row  = row_q;
		wr_col  = col_q;
		we      = 1'b1;
		wr_char = item_s1.char_code;
		if (is_set) begin
			row_nx = (item_s1.new_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : item_s1.new_row;
			col_nx = (item_s1.new_col > COL_W'(COLUMNS - 1)) ?
				COL_W'(COLUMNS - 1) : item_s1.new_col;
			we     = 1'b0;
		end else if (is_nl) begin
			col_nx = '0;
			row_nx = (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + ROW_W'(1);
			we     = 1'b0;
		end else if (is_tab) begin
			wr_char = CH_SPACE;
		end else if (is_bs) begin
			row_nx  = row_q;
			col_nx  = col_q - COL_W'(1);
			wr_col  = col_q - COL_W'(1);
			wr_char = CH_SPACE;
		end
	end

	// result word
	always_comb begin
		res_nx.write_enable = we;
		res_nx.cell_address = '0;
		res_nx.cell_value   = '0;
		if (we) begin
			res_nx.cell_address = ADDR_W'(wr_row) * ADDR_W'(COLUMNS) + ADDR_W'(wr_col);
			res_nx.cell_value   = {color_q, wr_char};
		end
		res_nx.cursor_row = row_nx;
		res_nx.cursor_col = col_nx;
		res_nx.last       = last_res;
	end

	// input register and tab counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			tab_cnt_s1 <= '0;
		end else if (cmd_valid && !cmd_stall) begin
			valid_s1   <= 1'b1;
			tab_cnt_s1 <= '0;
		end else if (fire && last_res) begin
			valid_s1   <= 1'b0;
			tab_cnt_s1 <= '0;
		end else if (fire) begin
			tab_cnt_s1 <= tab_cnt_s1 + TAB_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd_word;
		end
	end

	// cursor and colour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			color_q <= TEXT_COLOR_RESET;
		end else begin
			if (fire) begin
				row_q <= row_nx;
				col_q <= col_nx;
			end
			if (cfg_valid && cfg_ready) begin
				color_q <= cfg_data;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_word_q <= res_nx;
		end
	end

	// checks
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word.cursor_row < ROW_W'(ROWS)) &&
			(res_word.cursor_col < COL_W'(COLUMNS)))
		else $error("result cursor off screen");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_word.write_enable |->
			(res_word.cell_address == '0) && (res_word.cell_value == '0))
		else $error("non-writing result carries cell data");

	a_tab_count: assert property (@(posedge clk) disable iff (!arst_n)
		tab_cnt_s1 != '0 |-> valid_s1 && is_tab)
		else $error("tab counter running without a tab");

	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(row_q) && $stable(col_q))
		else $error("cursor moved without a result");

endmodule

// File: tb/sv/tb_text_console_char_writer_unit.sv
`timescale 1ns / 100ps

module tb_text_console_char_writer_unit;
	import tccw_pkg::*;

	// Screen state mirror: cursor, colour and the result words still owed
	class screen_mirror;
		logic [COLOR_W-1:0] colour;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		res_word_t          owed_words[$];
		int                 failures;

		function new();
			colour   = TEXT_COLOR_RESET;
			row      = '0;
			col      = '0;
			failures = 0;
		endfunction

		function int pending();
			return owed_words.size();
		endfunction

		// Result word at the current cursor, cell fields only when writing
		function res_word_t cell_word(bit we, logic [CHAR_W-1:0] ch, bit fin);
			res_word_t w;
			w = '0;
			w.write_enable = we;
			if (we) begin
				w.cell_address = ADDR_W'(int'(row) * COLUMNS + int'(col));
				w.cell_value   = {colour, ch};
			end
			w.cursor_row = row;
			w.cursor_col = col;
			w.last       = fin;
			return w;
		endfunction

		function void next_row();
			if (int'(row) + 1 >= ROWS) row = '0;
			else row = row + 1'b1;
		endfunction

		// Write at the cursor, then step on with column then row wrap
		function void put_glyph(logic [CHAR_W-1:0] ch, bit fin);
			res_word_t w;
			w = cell_word(1'b1, ch, fin);
			if (int'(col) + 1 >= COLUMNS) begin
				col = '0;
				next_row();
			end else begin
				col = col + 1'b1;
			end
			w.cursor_row = row;
			w.cursor_col = col;
			owed_words.push_back(w);
		endfunction

		// Work out every result word an accepted command word causes
		function void absorb_command(cmd_word_t c);
			if (c.command == CMD_SET) begin
				row = (int'(c.new_row) > ROWS - 1) ? ROW_W'(ROWS - 1) : c.new_row;
				col = (int'(c.new_col) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : c.new_col;
				owed_words.push_back(cell_word(1'b0, '0, 1'b1));
			end else if (c.char_code == CH_NEWLINE) begin
				col = '0;
				next_row();
				owed_words.push_back(cell_word(1'b0, '0, 1'b1));
			end else if (c.char_code == CH_TAB) begin
				for (int k = 0; k < TAB_RESULTS; k++)
					put_glyph(CH_SPACE, k == TAB_RESULTS - 1);
			end else if (c.char_code == CH_BACKSPACE && col != '0) begin
				col = col - 1'b1;
				owed_words.push_back(cell_word(1'b1, CH_SPACE, 1'b1));
			end else begin
				// includes backspace at column zero, drawn as a glyph
				put_glyph(c.char_code, 1'b1);
			end
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void compare_result(res_word_t got);
			res_word_t want;
			if (owed_words.size() == 0) begin
				$error("result word with nothing pending: %h", got);
				failures++;
				return;
			end
			want = owed_words.pop_front();
			check_field("write_enable", want.write_enable, got.write_enable);
			check_field("cell_address", want.cell_address, got.cell_address);
			check_field("cell_value",   want.cell_value,   got.cell_value);
			check_field("cursor_row",   want.cursor_row,   got.cursor_row);
			check_field("cursor_col",   want.cursor_col,   got.cursor_col);
			check_field("last",         want.last,         got.last);
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 300000;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	cmd_word_t          cmd_word  = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	res_word_t          res_word;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [COLOR_W-1:0] cfg_data  = '0;

	bit          steady = 1'b0;
	int unsigned cycles = 0;
	screen_mirror mirror = new();

	text_console_char_writer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch all three channels at the clock edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				mirror.colour = cfg_data;
			if (cmd_valid && !cmd_stall)
				mirror.absorb_command(cmd_word);
			if (res_valid && !res_stall)
				mirror.compare_result(res_word);
		end
	end

	// Result side back-pressure
	always @(posedge clk) begin
		res_stall <= steady ? 1'b0 : ($urandom_range(99) < 18);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic cmd_word_t compose_command(logic cmd, logic [CHAR_W-1:0] ch,
			logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		cmd_word_t w;
		w.command   = cmd;
		w.char_code = ch;
		w.new_row   = r;
		w.new_col   = c;
		return w;
	endfunction

	// Mostly random character codes, with a fair share of control codes and cursor moves
	function automatic cmd_word_t random_command();
		cmd_word_t   w;
		int unsigned pick;
		w = compose_command(($urandom_range(99) < 15) ? CMD_SET : CMD_PUT,
			CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
		pick = $urandom_range(99);
		if (pick < 10)      w.char_code = CH_NEWLINE;
		else if (pick < 20) w.char_code = CH_TAB;
		else if (pick < 35) w.char_code = CH_BACKSPACE;
		return w;
	endfunction

	// Present one word, with a random gap first when not steady, and hold it until taken
	task automatic send_command(input cmd_word_t w);
		if (!steady) begin
			while ($urandom_range(99) < 18) begin
				cmd_valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_command(random_command());
	endtask

	// Stop sending and let every owed result word come out
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (mirror.pending() != 0) @(posedge clk);
	endtask

	task automatic load_colour(input logic [COLOR_W-1:0] c);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset colour, field extremes, every control code, wraps
		send_command(compose_command(CMD_PUT, 8'h41, 5'd31, 7'd127));
		send_command(compose_command(CMD_PUT, 8'h00, 5'd0, 7'd0));
		send_command(compose_command(CMD_PUT, 8'hFF, 5'd0, 7'd0));
		send_command(compose_command(CMD_PUT, CH_TAB, 5'd0, 7'd0));
		send_command(compose_command(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		send_command(compose_command(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0));
		// backspace at column zero is drawn as a glyph
		send_command(compose_command(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		// set position beyond the screen saturates
		send_command(compose_command(CMD_SET, 8'hFF, 5'd31, 7'd127));
		// last cell: column and row both wrap
		send_command(compose_command(CMD_PUT, 8'h7A, 5'd0, 7'd0));
		send_command(compose_command(CMD_SET, 8'h00, 5'd24, 7'd0));
		send_command(compose_command(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0));
		// tab running across the end of the screen
		send_command(compose_command(CMD_SET, 8'h00, 5'd24, 7'd77));
		send_command(compose_command(CMD_PUT, CH_TAB, 5'd0, 7'd0));
		send_command(compose_command(CMD_SET, 8'h00, 5'd25, 7'd80));
		send_command(compose_command(CMD_PUT, CH_BACKSPACE, 5'd31, 7'd127));
		send_command(compose_command(CMD_SET, CH_TAB, 5'd0, 7'd0));
		send_command(compose_command(CMD_PUT, CH_SPACE, 5'd0, 7'd0));
		send_command(compose_command(CMD_PUT, 8'h7F, 5'd0, 7'd0));
		send_command(compose_command(CMD_PUT, 8'h80, 5'd0, 7'd0));
		send_command(compose_command(CMD_SET, CH_NEWLINE, 5'd12, 7'd40));
		send_command(compose_command(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0));
		// column end without a row end
		send_command(compose_command(CMD_SET, 8'h00, 5'd5, 7'd79));
		send_command(compose_command(CMD_PUT, 8'h07, 5'd0, 7'd0));
		send_command(compose_command(CMD_PUT, 8'h0B, 5'd0, 7'd0));
		settle();

		// Random phases at the colour extremes and one in between
		load_colour(8'h00);
		send_random(160);
		settle();
		load_colour(8'hFF);
		send_random(160);
		settle();
		load_colour(COLOR_W'($urandom_range(254, 1)));
		send_random(60);
		steady <= 1'b1;
		send_random(100);
		steady <= 1'b0;
		send_random(40);
		settle();

		repeat (12) @(posedge clk);
		if (mirror.failures == 0 && mirror.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
